@@ src/audio_frame_jitter_buffer_macros.svh @@
// Assertion macros used by the checker file of the jitter buffer.
`ifndef AUDIO_FRAME_JITTER_BUFFER_MACROS_SVH
`define AUDIO_FRAME_JITTER_BUFFER_MACROS_SVH

// Same-cycle implication, sampled on clk and ignored while reset is asserted.
`define AFJB_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("jitter buffer assertion failed");

// Next-cycle implication, sampled on clk and ignored while reset is asserted.
`define AFJB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("jitter buffer assertion failed");

`endif

@@ src/afjb_pkg.sv @@
package afjb_pkg;

	localparam int SLOTS       = 64;
	localparam int FRAME_WORDS = 40;
	localparam int DEPTH       = SLOTS * FRAME_WORDS;
	localparam int ADDR_W      = $clog2(DEPTH);
	localparam int POS_W       = (FRAME_WORDS > 1) ? $clog2(FRAME_WORDS) : 1;
	localparam int COUNT_W     = 7;
	localparam int WORD_W      = 32;

	localparam logic [COUNT_W-1:0] SLOTS_CNT      = COUNT_W'(SLOTS);
	localparam logic [COUNT_W-1:0] THRESHOLD_RST  = COUNT_W'(10);
	localparam logic [POS_W-1:0]   POS_LAST       = POS_W'(FRAME_WORDS - 1);
	localparam logic [ADDR_W-1:0]  FRAME_STEP     = ADDR_W'(FRAME_WORDS);
	localparam logic [ADDR_W-1:0]  LAST_BASE      = ADDR_W'(DEPTH - FRAME_WORDS);

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_TICK  = 2'd1,
		OP_FLUSH = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_PLAY = 2'b10
	} state_t;

	// Base address of the slot after the one starting at base, wrapping at the ring end.
	function automatic logic [ADDR_W-1:0] next_base(input logic [ADDR_W-1:0] base);
		logic [ADDR_W-1:0] nxt;
		nxt = (base >= LAST_BASE) ? '0 : base + FRAME_STEP;
		return nxt;
	endfunction

endpackage

@@ src/afjb_ram.sv @@
module afjb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/audio_frame_jitter_buffer.sv @@
// Audio frame jitter buffer: a ring of 64 frame slots of 40 words each, held in
// one single-port-read RAM. Pushed words can be issued on every clock while no
// frame is playing. A tick that plays a frame holds busy high while the frame
// is read out one word per cycle through the RAM read port; the words appear on
// out_word in the cycle after each read, back to back, with result_strobe high
// and frame_last marking the final word. Results cannot be held off: the receiver
// must take each word in the cycle it is strobed. No clearing pass follows reset.
module audio_frame_jitter_buffer (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [1:0]                       opcode,
	input  logic [afjb_pkg::WORD_W-1:0]      sample_word,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [afjb_pkg::COUNT_W-1:0]     cfg_data,
	output logic                             result_strobe,
	output logic [afjb_pkg::WORD_W-1:0]      out_word,
	output logic                             frame_last,
	output logic [afjb_pkg::COUNT_W-1:0]     level
);

	afjb_pkg::state_t                  state_q;
	logic [afjb_pkg::COUNT_W-1:0]      thr_q;
	logic [afjb_pkg::ADDR_W-1:0]       read_base_q;
	logic [afjb_pkg::ADDR_W-1:0]       write_base_q;
	logic [afjb_pkg::COUNT_W-1:0]      frame_count_q;
	logic [afjb_pkg::POS_W-1:0]        word_pos_q;
	logic                              playing_q;
	logic [afjb_pkg::ADDR_W-1:0]       rd_addr_q;
	logic [afjb_pkg::POS_W-1:0]        rd_cnt_q;
	logic [afjb_pkg::COUNT_W-1:0]      level_q;
	logic                              valid_s1;
	logic                              last_s1;
	logic [afjb_pkg::COUNT_W-1:0]      level_s1;

	logic                              accept;
	logic                              do_push;
	logic                              do_tick;
	logic                              do_flush;
	logic                              drop;
	logic                              commit;
	logic [afjb_pkg::COUNT_W-1:0]      thr_eff;
	logic                              play_go;
	logic                              reading;
	logic                              rd_last;
	logic [afjb_pkg::ADDR_W-1:0]       waddr;

	assign busy      = (state_q == afjb_pkg::ST_PLAY);
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign do_push   = accept && (opcode == afjb_pkg::OP_PUSH);
	assign do_tick   = accept && (opcode == afjb_pkg::OP_TICK);
	assign do_flush  = accept && (opcode == afjb_pkg::OP_FLUSH);

	// A new frame arriving at a full ring overwrites the oldest frame.
	assign drop    = (word_pos_q == '0) && (frame_count_q >= afjb_pkg::SLOTS_CNT);
	assign commit  = (word_pos_q == afjb_pkg::POS_LAST);
	assign thr_eff = (thr_q > afjb_pkg::SLOTS_CNT) ? afjb_pkg::SLOTS_CNT : thr_q;
	assign play_go = (frame_count_q != '0) && ((frame_count_q >= thr_eff) || playing_q);

	assign reading = busy;
	assign rd_last = (rd_cnt_q == afjb_pkg::POS_LAST);
	assign waddr   = write_base_q + afjb_pkg::ADDR_W'(word_pos_q);

	afjb_ram #(
		.WIDTH(afjb_pkg::WORD_W),
		.DEPTH(afjb_pkg::DEPTH)
	) u_store (
		.clk  (clk),
		.we   (do_push),
		.waddr(waddr),
		.wdata(sample_word),
		.re   (reading),
		.raddr(rd_addr_q),
		.rdata(out_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= afjb_pkg::ST_IDLE;
			thr_q         <= afjb_pkg::THRESHOLD_RST;
			read_base_q   <= '0;
			write_base_q  <= '0;
			frame_count_q <= '0;
			word_pos_q    <= '0;
			playing_q     <= 1'b0;
			rd_addr_q     <= '0;
			rd_cnt_q      <= '0;
			level_q       <= '0;
			valid_s1      <= 1'b0;
			last_s1       <= 1'b0;
			level_s1      <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				thr_q <= cfg_data;
			end

			valid_s1 <= reading;
			last_s1  <= reading && rd_last;
			level_s1 <= level_q;

			unique case (state_q)
				afjb_pkg::ST_IDLE: begin
					if (do_push) begin
						if (drop) begin
							read_base_q <= afjb_pkg::next_base(read_base_q);
						end
						if (commit) begin
							word_pos_q   <= '0;
							write_base_q <= afjb_pkg::next_base(write_base_q);
						end else begin
							word_pos_q <= word_pos_q + 1'b1;
						end
						frame_count_q <= frame_count_q - afjb_pkg::COUNT_W'(drop)
							+ afjb_pkg::COUNT_W'(commit);
					end else if (do_tick) begin
						if (frame_count_q == '0) begin
							playing_q <= 1'b0;
						end else if (play_go) begin
							frame_count_q <= frame_count_q - 1'b1;
							level_q       <= frame_count_q - 1'b1;
							rd_addr_q     <= read_base_q;
							read_base_q   <= afjb_pkg::next_base(read_base_q);
							rd_cnt_q      <= '0;
							playing_q     <= 1'b1;
							state_q       <= afjb_pkg::ST_PLAY;
						end
					end else if (do_flush) begin
						read_base_q   <= '0;
						write_base_q  <= '0;
						frame_count_q <= '0;
						word_pos_q    <= '0;
						playing_q     <= 1'b0;
					end
				end
				afjb_pkg::ST_PLAY: begin
					rd_addr_q <= rd_addr_q + 1'b1;
					rd_cnt_q  <= rd_cnt_q + 1'b1;
					if (rd_last) begin
						state_q <= afjb_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= afjb_pkg::ST_IDLE;
				end
			endcase
		end
	end

	assign result_strobe = valid_s1;
	assign frame_last    = last_s1;
	assign level         = level_s1;

endmodule

@@ src/afjb_checker.sv @@
`include "audio_frame_jitter_buffer_macros.svh"

module afjb_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic [1:0]                   opcode,
	input logic                         result_strobe,
	input logic                         frame_last,
	input logic [afjb_pkg::COUNT_W-1:0] level
);

	// Every played word follows a cycle in which the block was reading.
	`AFJB_ASSERT_NOW(a_strobe_after_busy, result_strobe, $past(busy))
	`AFJB_ASSERT_NOW(a_last_is_strobed, frame_last, result_strobe)
	// A frame streams out without gaps and with one level value throughout.
	`AFJB_ASSERT_NEXT(a_frame_contiguous, result_strobe && !frame_last, result_strobe)
	`AFJB_ASSERT_NEXT(a_level_steady, result_strobe && !frame_last, $stable(level))
	`AFJB_ASSERT_NEXT(a_flush_idle, start && !busy && (opcode == afjb_pkg::OP_FLUSH), !busy)

endmodule

bind audio_frame_jitter_buffer afjb_checker u_afjb_checker (.*);

@@ verif/tb.sv @@
module tb;

	// The opcode field can carry a fourth code that the block must ignore.
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 1000;
	localparam int SETTLE_CYCLES = 4;

	typedef struct {
		logic [afjb_pkg::WORD_W-1:0]  word;
		logic                         last;
		logic [afjb_pkg::COUNT_W-1:0] level;
	} played_word_t;

	// Tracks the ring, the playout gate and the threshold, and holds the words that
	// playout ticks have scheduled but the block has not yet streamed out.
	class playout_scoreboard;
		logic [afjb_pkg::WORD_W-1:0] frame_mem [afjb_pkg::DEPTH];
		played_word_t due_words [$];
		int head_slot;
		int tail_slot;
		int frames_held;
		int fill_pos;
		bit gate_open;
		int threshold;
		int mismatches;
		int words_seen;
		int frames_played;
		int frames_dropped;

		function new();
			threshold = afjb_pkg::THRESHOLD_RST;
			mismatches = 0;
			words_seen = 0;
			frames_played = 0;
			frames_dropped = 0;
			clear_ring();
		endfunction

		function void clear_ring();
			head_slot = 0;
			tail_slot = 0;
			frames_held = 0;
			fill_pos = 0;
			gate_open = 0;
		endfunction

		function int step_slot(int s);
			return (s + 1 >= afjb_pkg::SLOTS) ? 0 : s + 1;
		endfunction

		function void note_item(logic [1:0] op, logic [afjb_pkg::WORD_W-1:0] w);
			int limit;
			played_word_t pw;
			case (op)
				afjb_pkg::OP_PUSH: begin
					// A new frame arriving at a full ring pushes out the oldest one.
					if (fill_pos == 0 && frames_held >= afjb_pkg::SLOTS) begin
						head_slot = step_slot(head_slot);
						frames_held--;
						frames_dropped++;
					end
					frame_mem[tail_slot * afjb_pkg::FRAME_WORDS + fill_pos] = w;
					fill_pos++;
					if (fill_pos >= afjb_pkg::FRAME_WORDS) begin
						fill_pos = 0;
						tail_slot = step_slot(tail_slot);
						frames_held++;
					end
				end
				afjb_pkg::OP_TICK: begin
					limit = (threshold > afjb_pkg::SLOTS) ? afjb_pkg::SLOTS : threshold;
					if (frames_held == 0) begin
						gate_open = 0;
					end else if (frames_held >= limit || gate_open) begin
						frames_held--;
						for (int k = 0; k < afjb_pkg::FRAME_WORDS; k++) begin
							pw.word = frame_mem[head_slot * afjb_pkg::FRAME_WORDS + k];
							pw.last = (k == afjb_pkg::FRAME_WORDS - 1);
							pw.level = afjb_pkg::COUNT_W'(frames_held);
							due_words.push_back(pw);
						end
						head_slot = step_slot(head_slot);
						gate_open = 1;
						frames_played++;
					end
				end
				afjb_pkg::OP_FLUSH: begin
					clear_ring();
				end
				default: begin
				end
			endcase
		endfunction

		function void check_word(logic [afjb_pkg::WORD_W-1:0] word, logic last,
				logic [afjb_pkg::COUNT_W-1:0] lvl);
			played_word_t pw;
			if (due_words.size() == 0) begin
				$display("%0t: unexpected word %h (last %b, level %0d)", $time, word, last, lvl);
				mismatches++;
				return;
			end
			pw = due_words.pop_front();
			words_seen++;
			if (word !== pw.word) begin
				$display("%0t: out_word expected %h, got %h", $time, pw.word, word);
				mismatches++;
			end
			if (last !== pw.last) begin
				$display("%0t: frame_last expected %b, got %b", $time, pw.last, last);
				mismatches++;
			end
			if (lvl !== pw.level) begin
				$display("%0t: level expected %0d, got %0d", $time, pw.level, lvl);
				mismatches++;
			end
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	logic [1:0]                    opcode;
	logic [afjb_pkg::WORD_W-1:0]   sample_word;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [afjb_pkg::COUNT_W-1:0]  cfg_data;
	logic                          result_strobe;
	logic [afjb_pkg::WORD_W-1:0]   out_word;
	logic                          frame_last;
	logic [afjb_pkg::COUNT_W-1:0]  level;

	playout_scoreboard sb = new();
	int items_sent = 0;
	int stall_cycles = 0;
	bit burst = 0;

	audio_frame_jitter_buffer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.opcode        (opcode),
		.sample_word   (sample_word),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.result_strobe (result_strobe),
		.out_word      (out_word),
		.frame_last    (frame_last),
		.level         (level)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && result_strobe)
			sb.check_word(out_word, frame_last, level);
	end

	// The run ends if nothing at all is accepted for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_strobe || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic logic [afjb_pkg::WORD_W-1:0] pick_word();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return $urandom;
	endfunction

	task automatic send(logic [1:0] op, logic [afjb_pkg::WORD_W-1:0] w);
		int gap;
		if ($urandom_range(0, 15) == 0)
			burst = !burst;
		gap = burst ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		sample_word <= w;
		do @(posedge clk); while (busy);
		sb.note_item(op, w);
		items_sent++;
	endtask

	task automatic push_words(int n);
		repeat (n) send(afjb_pkg::OP_PUSH, pick_word());
	endtask

	// Waits until every scheduled word has come out and the block has gone quiet.
	task automatic settle();
		start <= 1'b0;
		while (sb.due_words.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_threshold(logic [afjb_pkg::COUNT_W-1:0] v);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.threshold = v;
	endtask

	// Mostly whole frames and ticks, with partial frames, flushes and stray codes mixed in.
	task automatic run_mix(int target);
		int stop;
		int r;
		stop = items_sent + target;
		while (items_sent < stop) begin
			r = $urandom_range(0, 99);
			if (r < 55)
				push_words(afjb_pkg::FRAME_WORDS);
			else if (r < 65)
				push_words($urandom_range(1, afjb_pkg::FRAME_WORDS - 1));
			else if (r < 88)
				send(afjb_pkg::OP_TICK, $urandom);
			else if (r < 93)
				send(afjb_pkg::OP_FLUSH, $urandom);
			else if (r < 97)
				send(OP_UNUSED, $urandom);
			else
				send(afjb_pkg::OP_PUSH, pick_word());
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		opcode <= afjb_pkg::OP_PUSH;
		sample_word <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= afjb_pkg::THRESHOLD_RST;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset threshold: empty ticks, an ignored code, a partial frame and a flush.
		send(afjb_pkg::OP_TICK, '0);
		send(OP_UNUSED, '1);
		send(afjb_pkg::OP_PUSH, '0);
		send(afjb_pkg::OP_PUSH, '1);
		send(afjb_pkg::OP_TICK, '1);
		send(afjb_pkg::OP_FLUSH, '0);
		send(afjb_pkg::OP_TICK, '0);
		push_words(afjb_pkg::FRAME_WORDS * 2);
		send(afjb_pkg::OP_TICK, '0);

		// Two frames wait below the reset threshold; dropping it opens the gate.
		write_threshold(7'd1);
		send(afjb_pkg::OP_TICK, '0);
		send(afjb_pkg::OP_TICK, '0);
		send(afjb_pkg::OP_TICK, '0);
		write_threshold(7'd0);
		push_words(afjb_pkg::FRAME_WORDS);
		send(afjb_pkg::OP_TICK, '0);
		send(afjb_pkg::OP_TICK, '0);

		write_threshold(7'd1);
		run_mix(10);
		write_threshold(7'd0);
		run_mix(5);
		write_threshold(7'd3);
		run_mix(10);

		// A threshold above the ring size is clamped to the ring size.
		write_threshold(7'd127);
		send(afjb_pkg::OP_TICK, '0);
		send(afjb_pkg::OP_FLUSH, '0);
		send(afjb_pkg::OP_TICK, '0);

		settle();
		repeat (8) @(posedge clk);
		$display("Sent %0d items; %0d frames played (%0d words checked), %0d frames overrun.",
			items_sent, sb.frames_played, sb.words_seen, sb.frames_dropped);
		$display("Thresholds used: reset value, 0, 1, 3 and 127.");
		if (sb.mismatches == 0 && sb.due_words.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+src
src/afjb_pkg.sv
src/afjb_ram.sv
src/audio_frame_jitter_buffer.sv
src/afjb_checker.sv
verif/tb.sv
